// ===== src/htwm_pkg.sv =====
// Package with shared types, widths and constants of the hit time-window merge block.
`default_nettype none
package htwm_pkg;

  localparam int unsigned AXES_DEF = 3;

  // Widths of the merge arithmetic
  localparam int unsigned NUM_W  = 76;  // second-moment numerator
  localparam int unsigned DEN_W  = 25;  // unsaturated energy sum
  localparam int unsigned RAD_W  = 50;  // variance / moment
  localparam int unsigned ROOT_W = 25;  // square root result

  localparam logic [23:0] WINDOW_RST = 24'd16;
  localparam logic [23:0] MAX24      = 24'hFFFFFF;
  localparam logic [19:0] MAX20      = 20'hFFFFF;

  typedef struct packed {
    logic        [23:0] hit_time;
    logic        [19:0] hit_time_spread;
    logic signed [19:0] hit_pos_x;
    logic signed [19:0] hit_pos_y;
    logic signed [19:0] hit_pos_z;
    logic        [19:0] hit_spread_x;
    logic        [19:0] hit_spread_y;
    logic        [19:0] hit_spread_z;
    logic        [23:0] hit_energy;
    logic               last_hit;
  } hit_t;

  typedef struct packed {
    logic        [23:0] clus_time;
    logic        [23:0] clus_time_spread;
    logic signed [19:0] clus_pos_x;
    logic signed [19:0] clus_pos_y;
    logic signed [19:0] clus_pos_z;
    logic        [19:0] clus_spread_x;
    logic        [19:0] clus_spread_y;
    logic        [19:0] clus_spread_z;
    logic        [23:0] clus_energy;
    logic               end_of_list;
  } clus_t;

  // One quantity to combine: old cluster value/spread/energy and hit value/spread/energy
  typedef struct packed {
    logic signed [24:0] v1;
    logic        [23:0] s1;
    logic        [23:0] e1;
    logic signed [24:0] v2;
    logic        [23:0] s2;
    logic        [23:0] e2;
  } comb_op_t;

  typedef struct packed {
    logic signed [24:0] mean;
    logic        [24:0] spread;
  } comb_res_t;

endpackage
`default_nettype wire

// ===== src/htwm_if.sv =====
// Handshake interfaces of the hit, cluster and configuration channels.
`default_nettype none
interface htwm_hit_if;
  logic               valid;
  logic               ready;
  logic        [23:0] hit_time;
  logic        [19:0] hit_time_spread;
  logic signed [19:0] hit_pos_x;
  logic signed [19:0] hit_pos_y;
  logic signed [19:0] hit_pos_z;
  logic        [19:0] hit_spread_x;
  logic        [19:0] hit_spread_y;
  logic        [19:0] hit_spread_z;
  logic        [23:0] hit_energy;
  logic               last_hit;

  modport source (output valid, hit_time, hit_time_spread, hit_pos_x, hit_pos_y, hit_pos_z,
                  hit_spread_x, hit_spread_y, hit_spread_z, hit_energy, last_hit,
                  input ready);
  modport sink (input valid, hit_time, hit_time_spread, hit_pos_x, hit_pos_y, hit_pos_z,
                hit_spread_x, hit_spread_y, hit_spread_z, hit_energy, last_hit,
                output ready);
endinterface

interface htwm_clus_if;
  logic               valid;
  logic               ready;
  logic        [23:0] clus_time;
  logic        [23:0] clus_time_spread;
  logic signed [19:0] clus_pos_x;
  logic signed [19:0] clus_pos_y;
  logic signed [19:0] clus_pos_z;
  logic        [19:0] clus_spread_x;
  logic        [19:0] clus_spread_y;
  logic        [19:0] clus_spread_z;
  logic        [23:0] clus_energy;
  logic               end_of_list;

  modport source (output valid, clus_time, clus_time_spread, clus_pos_x, clus_pos_y,
                  clus_pos_z, clus_spread_x, clus_spread_y, clus_spread_z, clus_energy,
                  end_of_list, input ready);
  modport sink (input valid, clus_time, clus_time_spread, clus_pos_x, clus_pos_y,
                clus_pos_z, clus_spread_x, clus_spread_y, clus_spread_z, clus_energy,
                end_of_list, output ready);
endinterface

interface htwm_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/htwm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module htwm_div #(
  parameter int unsigned NW = htwm_pkg::NUM_W,
  parameter int unsigned DW = htwm_pkg::DEN_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic      [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== src/htwm_sqrt.sv =====
// Integer square root (floor), one result bit per cycle.
`default_nettype none
module htwm_sqrt #(
  parameter int unsigned RW = htwm_pkg::RAD_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [RW-1:0]   rad_i,
  output logic                 done_o,
  output logic      [RW/2-1:0] root_o
);
  localparam int unsigned CW = $clog2(RW / 2 + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] v_q, bit_q;
  logic [RW:0]   res_q, trial;
  logic          ge;

  assign trial = res_q + {1'b0, bit_q};
  assign ge    = {1'b0, v_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW / 2);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      v_q   <= rad_i;
      res_q <= '0;
      bit_q <= {2'b01, {(RW - 2){1'b0}}};
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - trial[RW-1:0];
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[RW/2-1:0];
endmodule
`default_nettype wire

// ===== src/htwm_comb.sv =====
// Shared combine unit: weighted mean and RMS spread of one quantity via one multiplier.
`default_nettype none
module htwm_comb (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire htwm_pkg::comb_op_t  op_i,
  input  wire logic [24:0]         ee_i,
  output logic                     done_o,
  output htwm_pkg::comb_res_t      res_o
);
  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_MUL  = 6'b000010,
    C_DIVM = 6'b000100,
    C_DIVA = 6'b001000,
    C_SQ   = 6'b010000,
    C_SQRT = 6'b100000
  } cstate_e;

  localparam logic [3:0] ST_S1SQ = 4'd0;
  localparam logic [3:0] ST_A1SQ = 4'd1;
  localparam logic [3:0] ST_Q1LO = 4'd2;
  localparam logic [3:0] ST_Q1HI = 4'd3;
  localparam logic [3:0] ST_S2SQ = 4'd4;
  localparam logic [3:0] ST_A2SQ = 4'd5;
  localparam logic [3:0] ST_Q2LO = 4'd6;
  localparam logic [3:0] ST_Q2HI = 4'd7;
  localparam logic [3:0] ST_A1E1 = 4'd8;
  localparam logic [3:0] ST_A2E2 = 4'd9;
  localparam logic [3:0] ST_AMSQ = 4'd10;

  localparam int unsigned NW = htwm_pkg::NUM_W;
  localparam int unsigned RW = htwm_pkg::RAD_W;

  cstate_e             state_q;
  logic [3:0]          step_q;
  logic                ph_q, done_q;
  htwm_pkg::comb_op_t  op_q;
  logic [24:0]         ee_q;
  logic [49:0]         prod_q, prod_d;
  logic [47:0]         t_q;
  logic [48:0]         qv_q;
  logic [NW-1:0]       num_q;
  logic signed [50:0]  sum_q;
  logic [RW-1:0]       mom_q;
  logic [23:0]         am_q;
  htwm_pkg::comb_res_t res_q;
  logic [23:0]         a1, a2;
  logic [24:0]         mx, my;
  logic [50:0]         sum_mag;
  logic                div_start, div_done, sq_start, sq_done;
  logic [NW-1:0]       div_num, div_quo;
  logic [RW-1:0]       rad;
  logic [RW/2-1:0]     root;

  assign a1 = op_q.v1[24] ? 24'(-op_q.v1) : op_q.v1[23:0];
  assign a2 = op_q.v2[24] ? 24'(-op_q.v2) : op_q.v2[23:0];

  always_comb begin
    mx = '0;
    my = '0;
    case (step_q)
      ST_S1SQ: begin mx = {1'b0, op_q.s1}; my = {1'b0, op_q.s1}; end
      ST_A1SQ: begin mx = {1'b0, a1}; my = {1'b0, a1}; end
      ST_Q1LO: begin mx = qv_q[24:0]; my = {1'b0, op_q.e1}; end
      ST_Q1HI: begin mx = {1'b0, qv_q[48:25]}; my = {1'b0, op_q.e1}; end
      ST_S2SQ: begin mx = {1'b0, op_q.s2}; my = {1'b0, op_q.s2}; end
      ST_A2SQ: begin mx = {1'b0, a2}; my = {1'b0, a2}; end
      ST_Q2LO: begin mx = qv_q[24:0]; my = {1'b0, op_q.e2}; end
      ST_Q2HI: begin mx = {1'b0, qv_q[48:25]}; my = {1'b0, op_q.e2}; end
      ST_A1E1: begin mx = {1'b0, a1}; my = {1'b0, op_q.e1}; end
      ST_A2E2: begin mx = {1'b0, a2}; my = {1'b0, op_q.e2}; end
      ST_AMSQ: begin mx = {1'b0, am_q}; my = {1'b0, am_q}; end
      default: begin mx = '0; my = '0; end
    endcase
  end

  assign prod_d  = mx * my;
  assign sum_mag = sum_q[50] ? 51'(-sum_q) : 51'(sum_q);

  assign div_start = (state_q == C_MUL && ph_q && step_q == ST_A2E2) ||
                     (state_q == C_DIVM && div_done);
  assign div_num   = (state_q == C_MUL) ? num_q
                   : NW'(sum_mag) + NW'(ee_q[24:1]);
  assign sq_start  = state_q == C_SQ && ph_q;
  assign rad       = (mom_q > prod_q) ? mom_q - prod_q : '0;

  htwm_div #(.NW(NW), .DW(htwm_pkg::DEN_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(ee_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  htwm_sqrt #(.RW(RW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(rad), .done_o(sq_done), .root_o(root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= ST_S1SQ;
      ph_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_MUL;
            step_q  <= ST_S1SQ;
            ph_q    <= 1'b0;
          end
        end
        C_MUL: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (step_q == ST_A2E2) state_q <= C_DIVM;
            else step_q <= step_q + 1'b1;
          end
        end
        C_DIVM: if (div_done) state_q <= C_DIVA;
        C_DIVA: begin
          if (div_done) begin
            state_q <= C_SQ;
            step_q  <= ST_AMSQ;
            ph_q    <= 1'b0;
          end
        end
        C_SQ: begin
          ph_q <= !ph_q;
          if (ph_q) state_q <= C_SQRT;
        end
        C_SQRT: begin
          if (sq_done) begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && start_i) begin
      op_q  <= op_i;
      ee_q  <= ee_i;
      num_q <= NW'(ee_i[24:1]);
      sum_q <= '0;
    end
    if ((state_q == C_MUL || state_q == C_SQ) && !ph_q) prod_q <= prod_d;
    if (state_q == C_MUL && ph_q) begin
      case (step_q)
        ST_S1SQ, ST_S2SQ: t_q  <= prod_q[47:0];
        ST_A1SQ, ST_A2SQ: qv_q <= 49'(t_q) + 49'(prod_q);
        ST_Q1LO, ST_Q2LO: num_q <= num_q + NW'(prod_q);
        ST_Q1HI, ST_Q2HI: num_q <= num_q + (NW'(prod_q) << 25);
        ST_A1E1: sum_q <= op_q.v1[24] ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
        ST_A2E2: sum_q <= sum_q + (op_q.v2[24] ? -$signed({1'b0, prod_q})
                                               : $signed({1'b0, prod_q}));
        default: t_q <= t_q;
      endcase
    end
    if (state_q == C_DIVM && div_done) mom_q <= div_quo[RW-1:0];
    if (state_q == C_DIVA && div_done) am_q <= div_quo[23:0];
    if (state_q == C_SQRT && sq_done) begin
      res_q.mean   <= sum_q[50] ? -$signed({1'b0, am_q}) : $signed({1'b0, am_q});
      res_q.spread <= 25'(root);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire

// ===== src/hit_time_window_merge.sv =====
// Top level of the hit time-window merge: cluster state, sequencer and output register.
//
//  channel | dir | handshake      | payload
//  hit_i   | in  | valid / ready  | hit time, spreads, position, energy, last_hit
//  clus_o  | out | valid / ready  | cluster time, spreads, position, energy, end_of_list
//  cfg_i   | in  | valid / ready  | merge_window (24 bit), ready always high
//
// A hit that opens or closes a cluster does not use the combine unit; a merging hit
// runs it once per quantity (time plus AXES axes) unless the summed energy is zero;
// each run holds two bit-serial 76-step divisions and the 25-step square root.
// hit_i.ready is high only while the sequencer is idle.
// A result waits in the output register; a second result stalls the sequencer until
// the first is transferred. Reset clears the open-cluster flag and sets the window to 16.
`default_nettype none
module hit_time_window_merge #(
  parameter int unsigned AXES = htwm_pkg::AXES_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  htwm_hit_if.sink   hit_i,
  htwm_clus_if.source clus_o,
  htwm_cfg_if.sink   cfg_i
);
  localparam int unsigned QIW = $clog2(AXES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_EMITC = 7'b0000100,
    S_MERGE = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_LAST  = 7'b0100000,
    S_EMITF = 7'b1000000
  } state_e;

  state_e              state_q;
  logic [QIW-1:0]      qi_q;
  logic                open_q, out_valid_q;
  logic [23:0]         window_q;
  htwm_pkg::hit_t      hit_q;
  htwm_pkg::clus_t     out_q, snap;
  logic [23:0]         acc_time_q, acc_tspr_q, acc_energy_q;
  logic signed [19:0]  acc_pos_q [AXES];
  logic [19:0]         acc_spr_q [AXES];
  logic signed [19:0]  hpos [3];
  logic [19:0]         hspr [3];
  logic signed [19:0]  opos [3];
  logic [19:0]         ospr [3];
  logic [24:0]         ee;
  logic                slot_free, hit_xfer, window_out;
  logic                comb_start, comb_done;
  htwm_pkg::comb_op_t  op;
  htwm_pkg::comb_res_t res;

  assign hit_xfer  = hit_i.valid && hit_i.ready;
  assign slot_free = !out_valid_q || clus_o.ready;
  assign ee        = {1'b0, acc_energy_q} + {1'b0, hit_q.hit_energy};
  assign window_out = {1'b0, hit_q.hit_time} > ({1'b0, acc_time_q} + {1'b0, window_q});

  assign hpos[0] = hit_q.hit_pos_x;
  assign hpos[1] = hit_q.hit_pos_y;
  assign hpos[2] = hit_q.hit_pos_z;
  assign hspr[0] = hit_q.hit_spread_x;
  assign hspr[1] = hit_q.hit_spread_y;
  assign hspr[2] = hit_q.hit_spread_z;

  for (genvar a = 0; a < 3; a++) begin : g_out_axis
    if (a < AXES) begin : g_used
      assign opos[a] = acc_pos_q[a];
      assign ospr[a] = acc_spr_q[a];
    end else begin : g_unused
      assign opos[a] = '0;
      assign ospr[a] = '0;
    end
  end

  always_comb begin
    snap.clus_time        = acc_time_q;
    snap.clus_time_spread = acc_tspr_q;
    snap.clus_pos_x       = opos[0];
    snap.clus_pos_y       = opos[1];
    snap.clus_pos_z       = opos[2];
    snap.clus_spread_x    = ospr[0];
    snap.clus_spread_y    = ospr[1];
    snap.clus_spread_z    = ospr[2];
    snap.clus_energy      = acc_energy_q;
    snap.end_of_list      = (state_q == S_EMITF);
  end

  // Operands of the quantity under work: time first, then each axis
  always_comb begin
    op.v1 = $signed({1'b0, acc_time_q});
    op.s1 = acc_tspr_q;
    op.e1 = acc_energy_q;
    op.v2 = $signed({1'b0, hit_q.hit_time});
    op.s2 = {4'b0, hit_q.hit_time_spread};
    op.e2 = hit_q.hit_energy;
    for (int a = 0; a < AXES; a++) begin
      if (qi_q == QIW'(a + 1)) begin
        op.v1 = 25'(acc_pos_q[a]);
        op.s1 = {4'b0, acc_spr_q[a]};
        op.v2 = 25'(hpos[a]);
        op.s2 = {4'b0, hspr[a]};
      end
    end
  end

  assign comb_start = (state_q == S_MERGE) && (ee != '0);

  htwm_comb u_comb (
    .clk_i, .rst_ni, .start_i(comb_start), .op_i(op), .ee_i(ee),
    .done_o(comb_done), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      qi_q         <= '0;
      open_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      window_q     <= htwm_pkg::WINDOW_RST;
      acc_time_q   <= '0;
      acc_tspr_q   <= '0;
      acc_energy_q <= '0;
      for (int a = 0; a < AXES; a++) begin
        acc_pos_q[a] <= '0;
        acc_spr_q[a] <= '0;
      end
    end else begin
      if (cfg_i.valid) window_q <= cfg_i.data;
      if (out_valid_q && clus_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: if (hit_xfer) state_q <= S_CHECK;
        S_CHECK: begin
          if (!open_q) begin
            open_q       <= 1'b1;
            acc_time_q   <= hit_q.hit_time;
            acc_tspr_q   <= {4'b0, hit_q.hit_time_spread};
            acc_energy_q <= hit_q.hit_energy;
            for (int a = 0; a < AXES; a++) begin
              acc_pos_q[a] <= hpos[a];
              acc_spr_q[a] <= hspr[a];
            end
            state_q <= S_LAST;
          end else if (window_out) begin
            state_q <= S_EMITC;
          end else begin
            qi_q    <= '0;
            state_q <= S_MERGE;
          end
        end
        S_EMITC: begin
          // Hand the closed cluster over, then reopen from the hit
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            acc_time_q   <= hit_q.hit_time;
            acc_tspr_q   <= {4'b0, hit_q.hit_time_spread};
            acc_energy_q <= hit_q.hit_energy;
            for (int a = 0; a < AXES; a++) begin
              acc_pos_q[a] <= hpos[a];
              acc_spr_q[a] <= hspr[a];
            end
            state_q <= S_LAST;
          end
        end
        S_MERGE: state_q <= (ee == '0) ? S_LAST : S_WAIT;
        S_WAIT: begin
          if (comb_done) begin
            if (qi_q == '0) begin
              acc_time_q <= res.mean[23:0];
              acc_tspr_q <= res.spread[24] ? htwm_pkg::MAX24 : res.spread[23:0];
            end
            for (int a = 0; a < AXES; a++) begin
              if (qi_q == QIW'(a + 1)) begin
                acc_pos_q[a] <= res.mean[19:0];
                acc_spr_q[a] <= (res.spread[24:20] != '0) ? htwm_pkg::MAX20
                                                          : res.spread[19:0];
              end
            end
            if (qi_q == QIW'(AXES)) begin
              acc_energy_q <= ee[24] ? htwm_pkg::MAX24 : ee[23:0];
              state_q      <= S_LAST;
            end else begin
              qi_q    <= qi_q + 1'b1;
              state_q <= S_MERGE;
            end
          end
        end
        S_LAST: state_q <= hit_q.last_hit ? S_EMITF : S_IDLE;
        S_EMITF: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            open_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_xfer) begin
      hit_q.hit_time        <= hit_i.hit_time;
      hit_q.hit_time_spread <= hit_i.hit_time_spread;
      hit_q.hit_pos_x       <= hit_i.hit_pos_x;
      hit_q.hit_pos_y       <= hit_i.hit_pos_y;
      hit_q.hit_pos_z       <= hit_i.hit_pos_z;
      hit_q.hit_spread_x    <= hit_i.hit_spread_x;
      hit_q.hit_spread_y    <= hit_i.hit_spread_y;
      hit_q.hit_spread_z    <= hit_i.hit_spread_z;
      hit_q.hit_energy      <= hit_i.hit_energy;
      hit_q.last_hit        <= hit_i.last_hit;
    end
    if ((state_q == S_EMITC || state_q == S_EMITF) && slot_free) out_q <= snap;
  end

  assign hit_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign clus_o.valid            = out_valid_q;
  assign clus_o.clus_time        = out_q.clus_time;
  assign clus_o.clus_time_spread = out_q.clus_time_spread;
  assign clus_o.clus_pos_x       = out_q.clus_pos_x;
  assign clus_o.clus_pos_y       = out_q.clus_pos_y;
  assign clus_o.clus_pos_z       = out_q.clus_pos_z;
  assign clus_o.clus_spread_x    = out_q.clus_spread_x;
  assign clus_o.clus_spread_y    = out_q.clus_spread_y;
  assign clus_o.clus_spread_z    = out_q.clus_spread_z;
  assign clus_o.clus_energy      = out_q.clus_energy;
  assign clus_o.end_of_list      = out_q.end_of_list;
endmodule
`default_nettype wire

// ===== src/htwm_chk.sv =====
// Port checker of the hit time-window merge, bound to the top level.
`default_nettype none
module htwm_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        hit_valid_i,
  input wire logic        hit_ready_i,
  input wire logic        clus_valid_i,
  input wire logic        clus_ready_i,
  input wire logic [23:0] clus_time_i,
  input wire logic [23:0] clus_energy_i
);
  a_clus_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clus_valid_i && !clus_ready_i |=> clus_valid_i)
    else $error("cluster result dropped before transfer");

  a_clus_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clus_valid_i && !clus_ready_i |=> $stable(clus_time_i) && $stable(clus_energy_i))
    else $error("stalled cluster result changed");

  a_busy_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_valid_i && hit_ready_i |=> !hit_ready_i)
    else $error("hit accepted while previous hit still in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(clus_valid_i) |-> !$past(hit_ready_i))
    else $error("cluster result appeared while sequencer idle");
endmodule

bind hit_time_window_merge htwm_chk u_htwm_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .hit_valid_i(hit_i.valid),
  .hit_ready_i(hit_i.ready),
  .clus_valid_i(clus_o.valid),
  .clus_ready_i(clus_o.ready),
  .clus_time_i(clus_o.clus_time),
  .clus_energy_i(clus_o.clus_energy)
);
`default_nettype wire
